### design/tqe_pkg.sv
// ----------------------------------------------------------------------------
// tqe_pkg
// Shared types and constants for the ordered timeout list: operation and
// status codes, controller states, and the command/status bundles.
// ----------------------------------------------------------------------------
package tqe_pkg;

  localparam int KEY_W       = 15;
  localparam int TIMEOUT_W   = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

  // a single tick pops at most this many entries
  localparam int MAX_RESULTS = 16;
  localparam int POP_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_BAD_KEY      = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_EXPIRED      = 3'd4,
    ST_NONE_EXPIRED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_POP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    push_wr;        // append entry at tail
    logic    shift_wr;       // copy current entry one slot down
    logic    key_load;       // capture search key
    logic    cur_load_head;  // cursor to head
    logic    cur_adv;        // cursor and index forward by one
    logic    idx_clr;
    logic    cnt_dec;
    logic    pop;            // drop head entry into pending register
    logic    pop_clr;
    logic    now_inc;
    logic    emit;           // load output register
    status_t emit_status;
    logic    emit_pending;   // output key from pending register
    logic    emit_last;
  } tqe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic scan_end;
    logic key_match;
    logic head_expired;
    logic pop_room;
    logic have_popped;
  } tqe_stat_t;

endpackage

### design/tqe_ctrl.sv
// ----------------------------------------------------------------------------
// tqe_ctrl
// Controller FSM: decodes operations, sequences search/compaction and
// head expiry, and drives datapath commands.
// ----------------------------------------------------------------------------
module tqe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_operation,
  input  logic                in_key_neg,
  input  tqe_pkg::tqe_stat_t  stat,
  output logic                busy,
  output tqe_pkg::tqe_cmd_t   cmd
);
  import tqe_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.emit_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_operation)
            OP_PUSH: begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              if (in_key_neg) begin
                cmd.emit_status = ST_BAD_KEY;
              end else if (stat.full) begin
                cmd.emit_status = ST_FULL;
              end else begin
                cmd.push_wr     = 1'b1;
                cmd.emit_status = ST_OK;
              end
            end
            OP_REMOVE: begin
              if (in_key_neg) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = ST_BAD_KEY;
              end else begin
                cmd.key_load      = 1'b1;
                cmd.cur_load_head = 1'b1;
                cmd.idx_clr       = 1'b1;
                state_nxt         = S_SCAN;
              end
            end
            OP_TICK: begin
              cmd.now_inc       = 1'b1;
              cmd.cur_load_head = 1'b1;
              cmd.pop_clr       = 1'b1;
              state_nxt         = S_POP;
            end
            default: begin
              // unused code: no state change, no beat
            end
          endcase
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = ST_NOT_FOUND;
          state_nxt       = S_IDLE;
        end else begin
          cmd.cur_adv = 1'b1;
          if (stat.key_match) begin
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (stat.scan_end) begin
          cmd.cnt_dec     = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = ST_OK;
          state_nxt       = S_IDLE;
        end else begin
          cmd.shift_wr = 1'b1;
          cmd.cur_adv  = 1'b1;
        end
      end
      S_POP: begin
        if (stat.pop_room && stat.head_expired) begin
          // previous pop goes out now; its last flag depends on this one
          cmd.pop          = 1'b1;
          cmd.cur_adv      = 1'b1;
          cmd.emit         = stat.have_popped;
          cmd.emit_status  = ST_EXPIRED;
          cmd.emit_pending = 1'b1;
        end else begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          if (stat.have_popped) begin
            cmd.emit_status  = ST_EXPIRED;
            cmd.emit_pending = 1'b1;
          end else begin
            cmd.emit_status = ST_NONE_EXPIRED;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_remove_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && in_operation == OP_REMOVE && !in_key_neg)
      |=> (state_r == S_SCAN))
    else $error("accepted remove did not enter search");

  a_pending_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_pending) |-> stat.have_popped)
    else $error("expired beat without a popped entry");

endmodule

### design/tqe_datapath.sv
// ----------------------------------------------------------------------------
// tqe_datapath
// Entry memory (circular list), head/count/time registers, search cursor,
// pending-expiry register and the registered result port.
// ----------------------------------------------------------------------------
module tqe_datapath #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tqe_pkg::tqe_cmd_t             cmd,
  input  logic [tqe_pkg::KEY_W-1:0]     in_key_mag,
  input  logic                          cfg_wr_en,
  input  logic [tqe_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  output tqe_pkg::tqe_stat_t            stat,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [tqe_pkg::KEY_W-1:0]     out_expired_key,
  output logic                          out_last
);
  import tqe_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_W + TIME_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
  localparam logic [AW:0]   CAP_WIDE  = (AW + 1)'(CAPACITY);

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  // entry = {key, deadline}
  logic [EW-1:0]          mem [CAPACITY];
  logic [EW-1:0]          rd_r;

  logic [AW-1:0]          head_r, cur_r, prev_r, cur_nxt;
  logic [CW-1:0]          cnt_r, idx_r;
  logic [TIME_BITS-1:0]   now_r;
  logic [TIMEOUT_W-1:0]   timeout_r;
  logic [KEY_W-1:0]       skey_r, pend_r;
  logic [POP_W-1:0]       pop_n_r;

  logic                   out_valid_r, out_last_r;
  status_t                out_status_r;
  logic [KEY_W-1:0]       out_key_r;

  logic [AW:0]            tail_sum, tail_wrap;
  logic [AW-1:0]          tail_addr;
  logic [TIME_BITS-1:0]   deadline;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [EW-1:0]          wr_data;

  assign tail_sum  = (AW + 1)'(head_r) + (AW + 1)'(cnt_r);
  assign tail_wrap = (tail_sum >= CAP_WIDE) ? tail_sum - CAP_WIDE : tail_sum;
  assign tail_addr = tail_wrap[AW-1:0];
  assign deadline  = now_r + TIME_BITS'(timeout_r);

  assign cur_nxt = cmd.cur_load_head ? head_r :
                   cmd.cur_adv       ? addr_inc(cur_r) : cur_r;

  assign wr_en   = cmd.push_wr | cmd.shift_wr;
  assign wr_addr = cmd.push_wr ? tail_addr : prev_r;
  assign wr_data = cmd.push_wr ? {in_key_mag, deadline} : rd_r;

  // entry memory: one write, one registered read at the next cursor
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[cur_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      cnt_r     <= '0;
      now_r     <= '0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (cmd.now_inc) begin
        now_r <= now_r + 1'b1;
      end
      if (cmd.pop) begin
        head_r <= addr_inc(head_r);
      end
      if (cmd.push_wr) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.cnt_dec || cmd.pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (cmd.cur_adv) begin
      prev_r <= cur_r;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.cur_adv) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.key_load) begin
      skey_r <= in_key_mag;
    end
    if (cmd.pop) begin
      pend_r <= rd_r[EW-1:TIME_BITS];
    end
    if (cmd.pop_clr) begin
      pop_n_r <= '0;
    end else if (cmd.pop) begin
      pop_n_r <= pop_n_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_key_r    <= cmd.emit_pending ? pend_r : '0;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_expired_key = out_key_r;
  assign out_last        = out_last_r;

  assign stat.full         = (cnt_r == CAP_CNT);
  assign stat.scan_end     = (idx_r >= cnt_r);
  assign stat.key_match    = (rd_r[EW-1:TIME_BITS] == skey_r);
  assign stat.head_expired = (cnt_r != '0) && (rd_r[TIME_BITS-1:0] <= now_r);
  assign stat.pop_room     = (pop_n_r < POP_W'(MAX_RESULTS));
  assign stat.have_popped  = (pop_n_r != '0);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> !stat.full)
    else $error("append into full list");

  a_pop_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (cnt_r != '0) && stat.pop_room)
    else $error("pop from empty list or past per-tick limit");

endmodule

### design/timeout_queue_expiry.sv
// ----------------------------------------------------------------------------
// timeout_queue_expiry
// Ordered timeout list: insertion-ordered keys with deadlines, remove by
// key with compaction, and head expiry on each time tick.
// ----------------------------------------------------------------------------
// Latency: push, and push or remove with a negative key, give one beat the
//   cycle after accept with busy low; an unused operation code gives none.
// Remove: busy for the search and then the compaction; a miss skips the
//   compaction and gives its beat when the search ends.
// Tick: busy while expired head entries are popped; beats one a cycle.
// Reset (sync, rst_n low): empty list, time 0, timeout 60. No result stall.
// ----------------------------------------------------------------------------
module timeout_queue_expiry #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic signed [15:0] in_key,
  // timeout register
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  // result channel
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [14:0]        out_expired_key,
  output logic               out_last
);
  import tqe_pkg::*;

  tqe_cmd_t  cmd;
  tqe_stat_t stat;

  // Controller: all sequencing lives here. Push is finished in the accept
  // cycle; remove walks SCAN, then SHIFT on a match; tick walks POP
  // until the head is not due, the list is empty or the per-tick beat limit is reached.
  tqe_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .in_key_neg   (in_key[15]),
    .stat         (stat),
    .busy         (busy),
    .cmd          (cmd)
  );

  // Datapath: circular entry store addressed from a head pointer, so a
  // pop is a pointer bump; remove moves later entries down one slot per
  // cycle. An expired key is held in a pending register so its last
  // flag is known when it leaves.
  tqe_datapath #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_key_mag      (in_key[14:0]),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_expired_key (out_expired_key),
    .out_last        (out_last)
  );

endmodule

### test/timeout_queue_expiry_test.sv
// ----------------------------------------------------------------------------
// timeout_queue_expiry_test
// Self-checking bench for the ordered timeout list. Commands go in on the
// start/busy channel and are run through a predictor that keeps its own
// copy of the list. Each out_valid beat is checked against the oldest
// predicted beat. The run starts with directed corner cases at the reset
// timeout and then moves through random phases, each with its own timeout
// and sender idling.
// ----------------------------------------------------------------------------
module timeout_queue_expiry_test;
  import tqe_pkg::*;

  localparam int CAPACITY  = 16;
  localparam int TIME_BITS = 32;

  // code 3 has no name in the package; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // longest quiet stretch in a correct run: remove search plus compaction,
  // a config pause, or a long sender gap
  localparam int SETTLE_CYCLES = CAPACITY + 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int SHOW_LIMIT    = 10;
  localparam int NUM_PHASES    = 5;

  // Random phases. The receiver cannot hold results off, so the phase that
  // would stall it runs the sender back to back. Timeout 0 is the zero
  // timeout corner; 65535 leaves entries stuck at the head, so entries
  // pushed in later phases wait behind them.
  int phase_timeout[NUM_PHASES] = '{1, 65535, 5, 0, 12};
  int phase_idle[NUM_PHASES]    = '{0, 88, 0, 31, 0};
  int phase_items[NUM_PHASES]   = '{70, 30, 70, 40, 70};

  typedef struct {
    status_t           status;
    logic [KEY_W-1:0]  key;
    logic              last;
  } beat_t;

  // Holds the predicted list and the beats still owed by the block.
  class timeout_list_board;
    logic [KEY_W-1:0]     live_keys[$];
    logic [TIME_BITS-1:0] live_deadlines[$];
    logic [TIME_BITS-1:0] clock_now;
    logic [TIMEOUT_W-1:0] timeout_cfg;
    beat_t                expected_beats[$];
    int                   mismatches;

    function new();
      clock_now   = '0;
      timeout_cfg = TIMEOUT_RESET;
      mismatches  = 0;
    endfunction

    function void add_beat(status_t st, logic [KEY_W-1:0] k, logic lst);
      beat_t b;
      b.status = st;
      b.key    = k;
      b.last   = lst;
      expected_beats = {expected_beats, b};
    endfunction

    // Apply one accepted command to the list and queue the beats it owes.
    function void note_command(logic [1:0] op, logic [15:0] key);
      logic             neg;
      logic [KEY_W-1:0] k;
      int               hit;
      int               popped;
      neg    = key[15];
      k      = key[KEY_W-1:0];
      hit    = -1;
      popped = 0;
      case (op)
        OP_PUSH: begin
          if (neg) begin
            add_beat(ST_BAD_KEY, '0, 1'b1);
          end else if (live_keys.size() >= CAPACITY) begin
            add_beat(ST_FULL, '0, 1'b1);
          end else begin
            live_keys      = {live_keys, k};
            live_deadlines = {live_deadlines, clock_now + TIME_BITS'(timeout_cfg)};
            add_beat(ST_OK, '0, 1'b1);
          end
        end
        OP_REMOVE: begin
          if (neg) begin
            add_beat(ST_BAD_KEY, '0, 1'b1);
          end else begin
            // first match only; duplicates behind it stay
            foreach (live_keys[i])
              if (hit < 0 && live_keys[i] == k) hit = i;
            if (hit >= 0) begin
              live_keys.delete(hit);
              live_deadlines.delete(hit);
              add_beat(ST_OK, '0, 1'b1);
            end else begin
              add_beat(ST_NOT_FOUND, '0, 1'b1);
            end
          end
        end
        OP_TICK: begin
          clock_now = clock_now + 1'b1;
          // only the head is tested; plain unsigned compare
          while (popped < MAX_RESULTS && live_keys.size() > 0 &&
                 live_deadlines[0] <= clock_now) begin
            add_beat(ST_EXPIRED, live_keys[0], 1'b0);
            void'(live_keys.pop_front());
            void'(live_deadlines.pop_front());
            popped++;
          end
          if (popped == 0) add_beat(ST_NONE_EXPIRED, '0, 1'b1);
          else expected_beats[expected_beats.size()-1].last = 1'b1;
        end
        default: ;  // unused code: no beat, no state change
      endcase
    endfunction

    function void check_beat(logic [2:0] st, logic [KEY_W-1:0] k, logic lst);
      beat_t want;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected beat: status %0d key %0d last %0b", st, k, lst);
        return;
      end
      want = expected_beats.pop_front();
      if (st !== want.status || k !== want.key || lst !== want.last) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("mismatch: exp st %0d key %0d last %0b, got st %0d key %0d last %0b",
                   want.status, want.key, want.last, st, k, lst);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_operation = OP_PUSH;
  logic signed [15:0] in_key = '0;
  logic               cfg_wr_en = 1'b0;
  logic [15:0]        cfg_wr_data = '0;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [14:0]        out_expired_key;
  logic               out_last;

  timeout_list_board board;
  int idle_pct = 0;
  int quiet_cycles = 0;

  timeout_queue_expiry #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_expired_key (out_expired_key),
    .out_last        (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Result monitor and watchdog. Sampled at the rising edge, so both see
  // the values from before the edge. The watchdog restarts on any accepted
  // command or result beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1)
        board.check_beat(out_status, out_expired_key, out_last);
      if ((start && busy === 1'b0) || out_valid === 1'b1) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Present one command beat, idling first at the current idle rate, and
  // hold it until the block takes it. Called and returns at a falling edge;
  // start stays high so a follow-up beat can go out with no gap.
  task automatic send_command(logic [1:0] op, logic [15:0] key);
    while ($urandom_range(0, 99) < idle_pct) begin
      start        <= 1'b0;
      in_operation <= 2'($urandom_range(0, 3));
      in_key       <= 16'($urandom_range(0, 65535));
      @(negedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    board.note_command(op, key);
    @(negedge clk);
  endtask

  // Timeout writes only with the block idle: every owed beat back, then a
  // pause in case an ignored command is still in flight.
  task automatic write_timeout(logic [15:0] value);
    start <= 1'b0;
    while (board.expected_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    board.timeout_cfg = value;
  endtask

  initial begin
    int          r;
    int          sent;
    logic [1:0]  op;
    logic [15:0] key;

    board = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed, at the reset timeout ----
    send_command(OP_TICK, 16'h0000);     // tick on empty list
    send_command(OP_REMOVE, 16'd7);      // remove on empty list
    send_command(OP_PUSH, 16'h0000);     // smallest key
    send_command(OP_PUSH, 16'h7FFF);     // largest key
    send_command(OP_PUSH, 16'hFFFF);     // negative keys refused
    send_command(OP_PUSH, 16'h8000);
    send_command(OP_REMOVE, 16'hFFFB);
    send_command(OP_UNUSED, 16'h5555);   // ignored, no beat
    send_command(OP_PUSH, 16'h0000);     // duplicate key
    send_command(OP_REMOVE, 16'h0000);   // takes the first of the two
    send_command(OP_REMOVE, 16'd123);    // no match
    send_command(OP_PUSH, 16'h2AAA);
    while (board.live_keys.size() < CAPACITY)
      send_command(OP_PUSH, 16'(board.live_keys.size() + 100));
    send_command(OP_PUSH, 16'h1234);     // full list
    // remove at the tail (longest search) and at the head, then refill
    send_command(OP_REMOVE, {1'b0, board.live_keys[CAPACITY-1]});
    send_command(OP_REMOVE, {1'b0, board.live_keys[0]});
    send_command(OP_PUSH, 16'h5555);
    send_command(OP_PUSH, 16'h4ACE);

    // Tick until the list drains. The entries share one deadline, so the
    // whole full list goes out on a single tick.
    while (board.live_keys.size() != 0)
      send_command(OP_TICK, 16'($urandom_range(0, 65535)));

    // ---- random phases ----
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_timeout(16'(phase_timeout[p]));
      idle_pct = phase_idle[p];
      sent = 0;
      while (sent < phase_items[p]) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          op  = OP_UNUSED;
          key = 16'($urandom_range(0, 65535));
        end else if (r < 8) begin
          op  = (r < 6) ? OP_PUSH : OP_REMOVE;
          key = {1'b1, 15'($urandom_range(0, 32767))};
        end else if (r < 48) begin
          // mostly a small key space so duplicates and hits are common
          op  = OP_PUSH;
          key = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 32767))
                                            : 16'($urandom_range(0, 31));
        end else if (r < 72) begin
          op = OP_REMOVE;
          if (board.live_keys.size() > 0 && $urandom_range(0, 4) != 0)
            key = {1'b0, board.live_keys[$urandom_range(0, board.live_keys.size() - 1)]};
          else
            key = 16'($urandom_range(0, 31));
        end else begin
          op  = OP_TICK;
          key = 16'($urandom_range(0, 65535));
        end
        send_command(op, key);
        if (op != OP_UNUSED) sent++;
      end
    end

    // ---- wind down ----
    start <= 1'b0;
    while (board.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.expected_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/tqe_pkg.sv
design/tqe_ctrl.sv
design/tqe_datapath.sv
design/timeout_queue_expiry.sv
test/timeout_queue_expiry_test.sv
